/* design/tfj_pkg.sv */
`default_nettype none
package tfj_pkg;
   localparam int MaxWidth  = 32;
   localparam int MaxWords  = 16;
   localparam int ColW      = 6;
   localparam int WordIdxW  = 4;
   localparam int WordCntW  = 5;
   localparam logic [7:0] SpaceChar = 8'd32;
   localparam logic [5:0] WidthReset = 6'd16;

   typedef struct packed {
      logic [7:0] char_in;
      logic       word_end;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       row_end;
      logic       run_last;
   } rsp_type;
endpackage
`default_nettype wire

/* design/tfj_if.sv */
`default_nettype none
interface tfj_req_if;
   import tfj_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

interface tfj_rsp_if;
   import tfj_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

interface tfj_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface
`default_nettype wire

/* design/tfj_ram.sv */
`default_nettype none
module tfj_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* design/text_full_justifier.sv */
`default_nettype none
// Channel | dir | payload                       | handshake
// req     | in  | char_in, word_end, text_end   | req_valid / req_ready
// rsp     | out | char_out, row_end, run_last   | rsp_valid / rsp_ready
// csr     | in  | max_width (6 bits)            | csr_valid / csr_ready
//
// A plain character is accepted and stored into the pending RAM. A word end of
// L characters that fits the row is accepted, stored, decided, copied into the
// row RAM, and its length recorded. A row is walked column by column, with a
// word length fetch before each word and one more after a last word that ends
// short of the row; a justified row first runs the space division. Reset is
// synchronous and clears counters and rsp valid and sets the width register to
// WidthReset; RAMs are never read before written. A stalled rsp holds the
// column walk, and requests and csr writes are taken only while idle.
module text_full_justifier
   import tfj_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   tfj_req_if.sink    req,
   tfj_rsp_if.source  rsp,
   tfj_csr_if.sink    csr
);
   typedef enum logic [3:0] {
      S_IDLE, S_STORE, S_DECIDE, S_DIVIDE, S_LEN_RD, S_LEN_GET,
      S_COL_RD, S_COL_OUT, S_COPY, S_ADD
   } state_type;

   state_type           state_ff;
   logic [ColW-1:0]     width_ff;
   req_type             req_ff;
   logic [ColW-1:0]     pend_len_ff;
   logic [WordCntW-1:0] word_cnt_ff;
   logic [ColW-1:0]     char_tot_ff;
   logic [ColW-1:0]     wlen_ff;
   logic                last_row_ff;
   // emission walk
   logic [ColW-1:0]     col_ff;
   logic [ColW-1:0]     pos_ff;
   logic [ColW-1:0]     src_ff;
   logic [ColW-1:0]     left_ff;
   logic [WordCntW-1:0] k_ff;
   // quotient / remainder of the space division
   logic [ColW-1:0]     base_ff;
   logic [WordCntW-1:0] extra_ff;
   logic [2:0]          div_cnt_ff;
   // word copy pipeline
   logic [ColW-1:0]     cp_ff;
   logic [ColW-1:0]     cp_wr_ff;
   logic                cp_vld_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   // effective width 1..32
   logic [ColW-1:0] w_eff;
   always_comb begin
      w_eff = width_ff;
      if (width_ff == 6'd0) w_eff = 6'd1;
      else if (width_ff > 6'(MaxWidth)) w_eff = 6'(MaxWidth);
   end

   // RAMs
   logic                pc_we, lc_we, wl_we;
   logic [4:0]          pc_wa, pc_ra, lc_wa, lc_ra;
   logic [7:0]          pc_wd, pc_rd, lc_wd, lc_rd;
   logic [WordIdxW-1:0] wl_wa, wl_ra;
   logic [ColW-1:0]     wl_wd, wl_rd;

   tfj_ram #(.Width(8), .Depth(MaxWidth)) u_pend (
      .clock, .wr_en(pc_we), .wr_addr(pc_wa), .wr_data(pc_wd),
      .rd_addr(pc_ra), .rd_data(pc_rd));
   tfj_ram #(.Width(8), .Depth(MaxWidth)) u_line (
      .clock, .wr_en(lc_we), .wr_addr(lc_wa), .wr_data(lc_wd),
      .rd_addr(lc_ra), .rd_data(lc_rd));
   tfj_ram #(.Width(6), .Depth(MaxWords)) u_wlen (
      .clock, .wr_en(wl_we), .wr_addr(wl_wa), .wr_data(wl_wd),
      .rd_addr(wl_ra), .rd_data(wl_rd));

   // pending word length after this character, cut to the row width
   logic            pend_room;
   logic [ColW-1:0] pend_next, word_len;
   assign pend_room = (pend_len_ff < w_eff);
   assign pend_next = pend_room ? pend_len_ff + 6'd1 : pend_len_ff;
   assign word_len  = (pend_next > w_eff) ? w_eff : pend_next;

   logic need_emit;
   assign need_emit = (word_cnt_ff != '0) &&
      ((word_cnt_ff >= 5'(MaxWords)) ||
       (7'(char_tot_ff) + 7'(word_cnt_ff) + 7'(wlen_ff) > 7'(w_eff)));

   // restoring division step: spaces / gaps, one quotient bit a cycle
   logic [WordCntW-1:0] gaps;
   logic [ColW-1:0]     spaces, div_trial, div_diff;
   logic                div_ge;
   assign gaps      = word_cnt_ff - 5'd1;
   assign spaces    = (w_eff > char_tot_ff) ? w_eff - char_tot_ff : 6'd0;
   assign div_trial = {extra_ff, base_ff[5]};
   assign div_ge    = (div_trial >= {1'b0, gaps});
   assign div_diff  = div_trial - {1'b0, gaps};

   // gap before word k
   logic [ColW-1:0] gap_step;
   assign gap_step = last_row_ff ? 6'd1 : base_ff + 6'(extra_ff != '0);

   // column value: current word char or space
   logic col_hit, col_last;
   assign col_hit  = (left_ff != '0) && (pos_ff == col_ff);
   assign col_last = (col_ff + 6'd1 == w_eff);

   logic [6:0] lc_sum, tot_sum;
   assign lc_sum  = 7'(char_tot_ff) + 7'(cp_wr_ff);
   assign tot_sum = 7'(char_tot_ff) + 7'(wlen_ff);

   logic rsp_free, out_fire;
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign out_fire = (state_ff == S_COL_OUT) && rsp_free;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // RAM control; phases never overlap, so no forwarding is needed
   always_comb begin
      pc_we = (state_ff == S_STORE) && pend_room;
      pc_wa = pend_len_ff[4:0];
      pc_wd = req_ff.char_in;
      pc_ra = cp_ff[4:0];
      lc_we = (state_ff == S_COPY) && cp_vld_ff && (lc_sum < 7'(MaxWidth));
      lc_wa = lc_sum[4:0];
      lc_wd = pc_rd;
      lc_ra = src_ff[4:0];
      wl_we = (state_ff == S_ADD) && (word_cnt_ff < 5'(MaxWords));
      wl_wa = word_cnt_ff[3:0];
      wl_wd = wlen_ff;
      wl_ra = k_ff[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WidthReset;
         pend_len_ff  <= '0;
         word_cnt_ff  <= '0;
         char_tot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= out_fire || (rsp_valid_ff && !rsp.ready);
         case (state_ff)
            S_IDLE: begin
               if (csr.valid) width_ff <= csr.data;
               if (req.valid) begin
                  req_ff   <= req.data;
                  state_ff <= S_STORE;
               end
            end
            S_STORE: begin
               if (!req_ff.word_end && !req_ff.text_end) begin
                  pend_len_ff <= pend_next;
                  state_ff    <= S_IDLE;
               end else begin
                  pend_len_ff <= '0;
                  wlen_ff     <= word_len;
                  state_ff    <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               // emit the open row first, or copy the word straight in
               cp_ff     <= '0;
               cp_vld_ff <= 1'b0;
               if (need_emit) begin
                  last_row_ff <= 1'b0;
                  base_ff     <= spaces;
                  extra_ff    <= '0;
                  div_cnt_ff  <= '0;
                  state_ff    <= S_DIVIDE;
               end else begin
                  state_ff <= S_COPY;
               end
            end
            S_DIVIDE: begin
               if (div_ge) begin
                  extra_ff <= div_diff[4:0];
                  base_ff  <= {base_ff[4:0], 1'b1};
               end else begin
                  extra_ff <= div_trial[4:0];
                  base_ff  <= {base_ff[4:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 3'd1;
               if (div_cnt_ff == 3'd5) begin
                  col_ff   <= '0;
                  pos_ff   <= '0;
                  src_ff   <= '0;
                  k_ff     <= '0;
                  left_ff  <= '0;
                  state_ff <= S_LEN_RD;
               end
            end
            S_LEN_RD: begin
               state_ff <= S_LEN_GET;
            end
            S_LEN_GET: begin
               // word k starts after its gap; past the last word nothing is left
               if (k_ff < word_cnt_ff) begin
                  left_ff <= wl_rd;
                  if (k_ff != '0) begin
                     pos_ff <= pos_ff + gap_step;
                     if (!last_row_ff && extra_ff != '0) extra_ff <= extra_ff - 5'd1;
                  end
               end else begin
                  left_ff <= '0;
               end
               state_ff <= S_COL_RD;
            end
            S_COL_RD: begin
               state_ff <= S_COL_OUT;
            end
            S_COL_OUT: begin
               if (rsp_free) begin
                  rsp_ff.char_out <= col_hit ? lc_rd : SpaceChar;
                  rsp_ff.row_end  <= col_last;
                  rsp_ff.run_last <= col_last && (last_row_ff || !req_ff.text_end);
                  col_ff <= col_ff + 6'd1;
                  if (col_hit) begin
                     src_ff  <= src_ff + 6'd1;
                     pos_ff  <= pos_ff + 6'd1;
                     left_ff <= left_ff - 6'd1;
                  end
                  if (col_last) begin
                     word_cnt_ff <= '0;
                     char_tot_ff <= '0;
                     state_ff    <= last_row_ff ? S_IDLE : S_COPY;
                  end else if (col_hit && left_ff == 6'd1) begin
                     k_ff     <= k_ff + 5'd1;
                     state_ff <= S_LEN_RD;
                  end else begin
                     state_ff <= S_COL_RD;
                  end
               end
            end
            S_COPY: begin
               // move pending word into the row RAM: read, then write next cycle
               if (cp_ff < wlen_ff) begin
                  cp_ff     <= cp_ff + 6'd1;
                  cp_wr_ff  <= cp_ff;
                  cp_vld_ff <= 1'b1;
               end else begin
                  cp_vld_ff <= 1'b0;
               end
               if (cp_ff == wlen_ff && (cp_vld_ff || wlen_ff == '0)) begin
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               if (word_cnt_ff < 5'(MaxWords)) begin
                  word_cnt_ff <= word_cnt_ff + 5'd1;
                  char_tot_ff <= (tot_sum > 7'(MaxWidth)) ? 6'(MaxWidth) : tot_sum[5:0];
               end
               if (req_ff.text_end) begin
                  last_row_ff <= 1'b1;
                  col_ff      <= '0;
                  pos_ff      <= '0;
                  src_ff      <= '0;
                  k_ff        <= '0;
                  left_ff     <= '0;
                  state_ff    <= S_LEN_RD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("rsp changed while stalled");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("req taken while busy");
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COL_OUT |-> col_ff < w_eff) else $error("column past row width");
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_len_ff <= 6'(MaxWidth)) else $error("pending length overflow");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      word_cnt_ff <= 5'(MaxWords)) else $error("word count overflow");
endmodule
`default_nettype wire
